FILE: src/infix_to_prefix_converter_macros.svh
// Assertion helpers for the checker file.
`ifndef INFIX_TO_PREFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_PREFIX_CONVERTER_MACROS_SVH

// Clocked check, masked while reset is high.
`define IPC_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define IPC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ipc_pkg.sv
package ipc_pkg;

  localparam int MAX_LEN     = 32;
  localparam int MAX_RESULTS = 32;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int CNT_W       = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd2;
  localparam logic [1:0] RANK_MUL  = 2'd3;

  // Finished expression handed from the loader to the converter.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } job_t;

  // Converter's hold on the expression buffer.
  typedef struct packed {
    logic              release_buf;
    logic [ADDR_W-1:0] addr;
  } buf_ctl_t;

  typedef enum logic {
    FR_LOAD,
    FR_HOLD
  } front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_FETCH,
    BK_CLASS,
    BK_PAREN,
    BK_OPLOOP,
    BK_FLUSH,
    BK_REFILL,
    BK_FINISH,
    BK_SINGLE,
    BK_EMIT_RD,
    BK_EMIT_LD
  } back_state_t;

  function automatic logic [1:0] op_rank(input logic [7:0] c);
    logic [1:0] r;
    case (c)
      CH_PLUS, CH_MINUS: r = RANK_ADD;
      CH_STAR, CH_SLASH: r = RANK_MUL;
      default:           r = RANK_NONE;
    endcase
    return r;
  endfunction

endpackage

FILE: src/ipc_ifs.sv
interface ipc_expr_if;
  logic       valid;
  logic       ready;
  logic [7:0] expr_char;
  logic       expr_last;

  modport source (output valid, output expr_char, output expr_last, input ready);
  modport sink   (input valid, input expr_char, input expr_last, output ready);
endinterface

interface ipc_prefix_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic       fault;

  modport source (output valid, output out_char, output out_last, output fault,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input fault,
                  output ready);
endinterface

FILE: src/ipc_front.sv
module ipc_front (
  input  logic                        clk,
  input  logic                        rst,
  ipc_expr_if.sink                    expr_in,
  output logic                        job_push,
  output ipc_pkg::job_t               job_data,
  input  logic                        job_full,
  input  ipc_pkg::buf_ctl_t           buf_ctl,
  output logic [7:0]                  buf_data
);

  logic [7:0] mem [ipc_pkg::MAX_LEN];

  ipc_pkg::front_state_t      state, state_next;
  logic [ipc_pkg::CNT_W-1:0]  count, count_next;
  logic                       ovf, ovf_next;
  logic                       accept;
  logic                       wr_en;

  assign expr_in.ready = (state == ipc_pkg::FR_LOAD) && !job_full;
  assign accept        = expr_in.valid && expr_in.ready;

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    job_push   = 1'b0;
    wr_en      = accept && (count < ipc_pkg::CNT_W'(ipc_pkg::MAX_LEN));
    job_data.count = wr_en ? count + ipc_pkg::CNT_W'(1) : count;
    job_data.ovf   = ovf || !wr_en;
    case (state)
      ipc_pkg::FR_LOAD: begin
        if (accept) begin
          count_next = job_data.count;
          ovf_next   = job_data.ovf;
          if (expr_in.expr_last) begin
            // hand the expression over and wait for the buffer back
            job_push   = 1'b1;
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = ipc_pkg::FR_HOLD;
          end
        end
      end
      ipc_pkg::FR_HOLD: begin
        if (buf_ctl.release_buf) state_next = ipc_pkg::FR_LOAD;
      end
      default: state_next = ipc_pkg::FR_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipc_pkg::FR_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[ipc_pkg::ADDR_W-1:0]] <= expr_in.expr_char;
    buf_data <= mem[buf_ctl.addr];
  end

endmodule

FILE: src/ipc_job_fifo.sv
module ipc_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ipc_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output ipc_pkg::job_t pop_data,
  output logic          empty
);

  ipc_pkg::job_t slot [2];
  logic          wp, rp;
  logic [1:0]    fill;
  logic          do_push, do_pop;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wp] <= push_data;
  end

endmodule

FILE: src/ipc_back.sv
module ipc_back (
  input  logic                clk,
  input  logic                rst,
  input  ipc_pkg::job_t       job,
  input  logic                job_empty,
  output logic                job_pop,
  output ipc_pkg::buf_ctl_t   buf_ctl,
  input  logic [7:0]          buf_data,
  ipc_prefix_if.source        prefix_out
);

  localparam int AW = ipc_pkg::ADDR_W;
  localparam int CW = ipc_pkg::CNT_W;

  logic [7:0] stk [ipc_pkg::MAX_LEN];
  logic [7:0] res [ipc_pkg::MAX_LEN];
  logic [7:0] stk_rd, res_rd;

  ipc_pkg::back_state_t state, state_next, ret, ret_next;
  logic [CW-1:0] idx, idx_next, sp, sp_next, rc, rc_next;
  logic [AW-1:0] eidx, eidx_next;
  logic          err, err_next;
  logic [7:0]    cur, cur_next, top, top_next;
  logic          ov, ov_next, olast, olast_next, ofault, ofault_next;
  logic [7:0]    och, och_next;

  logic          push_en, put_en, out_free;
  logic [7:0]    push_data, put_data;
  logic [CW-1:0] idx_m1, sp_m2, rc_m1;

  assign idx_m1   = idx - CW'(1);
  assign sp_m2    = sp - CW'(2);
  assign rc_m1    = rc - CW'(1);
  assign out_free = !ov || prefix_out.ready;

  assign prefix_out.valid    = ov;
  assign prefix_out.out_char = och;
  assign prefix_out.out_last = olast;
  assign prefix_out.fault    = ofault;

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    idx_next    = idx;
    sp_next     = sp;
    rc_next     = rc;
    eidx_next   = eidx;
    err_next    = err;
    cur_next    = cur;
    top_next    = top;
    ov_next     = ov && !prefix_out.ready;
    och_next    = och;
    olast_next  = olast;
    ofault_next = ofault;
    push_en     = 1'b0;
    push_data   = cur;
    put_en      = 1'b0;
    put_data    = top;
    job_pop     = 1'b0;
    buf_ctl.release_buf = 1'b0;
    buf_ctl.addr        = idx_m1[AW-1:0];
    case (state)
      ipc_pkg::BK_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          idx_next   = job.count;
          sp_next    = '0;
          rc_next    = '0;
          err_next   = job.ovf;
          state_next = ipc_pkg::BK_FETCH;
        end
      end
      ipc_pkg::BK_FETCH: begin
        // scan from the end of the expression toward its start
        if (idx == '0) begin
          state_next = ipc_pkg::BK_FLUSH;
        end else begin
          idx_next   = idx_m1;
          state_next = ipc_pkg::BK_CLASS;
        end
      end
      ipc_pkg::BK_CLASS: begin
        cur_next = buf_data;
        if (buf_data == ipc_pkg::CH_CLOSE) begin
          push_en    = 1'b1;
          push_data  = buf_data;
          state_next = ipc_pkg::BK_FETCH;
        end else if (buf_data == ipc_pkg::CH_OPEN) begin
          state_next = ipc_pkg::BK_PAREN;
        end else if (ipc_pkg::op_rank(buf_data) != ipc_pkg::RANK_NONE) begin
          state_next = ipc_pkg::BK_OPLOOP;
        end else begin
          put_en     = 1'b1;
          put_data   = buf_data;
          state_next = ipc_pkg::BK_FETCH;
        end
      end
      ipc_pkg::BK_PAREN: begin
        // pop to the matching close paren
        if (sp == '0) begin
          err_next   = 1'b1;
          state_next = ipc_pkg::BK_FINISH;
        end else begin
          sp_next    = sp - CW'(1);
          state_next = ipc_pkg::BK_REFILL;
          if (top == ipc_pkg::CH_CLOSE) begin
            ret_next = ipc_pkg::BK_FETCH;
          end else begin
            put_en   = 1'b1;
            ret_next = ipc_pkg::BK_PAREN;
          end
        end
      end
      ipc_pkg::BK_OPLOOP: begin
        if ((sp != '0) && (ipc_pkg::op_rank(top) > ipc_pkg::op_rank(cur))) begin
          sp_next    = sp - CW'(1);
          put_en     = 1'b1;
          ret_next   = ipc_pkg::BK_OPLOOP;
          state_next = ipc_pkg::BK_REFILL;
        end else begin
          push_en    = 1'b1;
          state_next = ipc_pkg::BK_FETCH;
        end
      end
      ipc_pkg::BK_FLUSH: begin
        if (sp == '0) begin
          state_next = ipc_pkg::BK_FINISH;
        end else if (top == ipc_pkg::CH_CLOSE) begin
          err_next   = 1'b1;
          state_next = ipc_pkg::BK_FINISH;
        end else begin
          sp_next    = sp - CW'(1);
          put_en     = 1'b1;
          ret_next   = ipc_pkg::BK_FLUSH;
          state_next = ipc_pkg::BK_REFILL;
        end
      end
      ipc_pkg::BK_REFILL: begin
        // stack read issued by the pop lands here
        top_next   = stk_rd;
        state_next = ret;
      end
      ipc_pkg::BK_FINISH: begin
        buf_ctl.release_buf = 1'b1;
        eidx_next = rc_m1[AW-1:0];
        if (rc > CW'(ipc_pkg::MAX_RESULTS)) err_next = 1'b1;
        if (err || (rc > CW'(ipc_pkg::MAX_RESULTS)) || (rc == '0)) begin
          state_next = ipc_pkg::BK_SINGLE;
        end else begin
          state_next = ipc_pkg::BK_EMIT_RD;
        end
      end
      ipc_pkg::BK_SINGLE: begin
        if (out_free) begin
          ov_next     = 1'b1;
          och_next    = 8'h00;
          olast_next  = 1'b1;
          ofault_next = err;
          state_next  = ipc_pkg::BK_IDLE;
        end
      end
      ipc_pkg::BK_EMIT_RD: begin
        if (out_free) state_next = ipc_pkg::BK_EMIT_LD;
      end
      ipc_pkg::BK_EMIT_LD: begin
        ov_next     = 1'b1;
        och_next    = res_rd;
        olast_next  = (eidx == '0);
        ofault_next = 1'b0;
        if (eidx == '0) begin
          state_next = ipc_pkg::BK_IDLE;
        end else begin
          eidx_next  = eidx - AW'(1);
          state_next = ipc_pkg::BK_EMIT_RD;
        end
      end
      default: state_next = ipc_pkg::BK_IDLE;
    endcase
    if (push_en) begin
      sp_next  = sp + CW'(1);
      top_next = push_data;
    end
    if (put_en) rc_next = rc + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipc_pkg::BK_IDLE;
      ret   <= ipc_pkg::BK_FETCH;
      ov    <= 1'b0;
      idx   <= '0;
      sp    <= '0;
      rc    <= '0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      ov    <= ov_next;
      idx   <= idx_next;
      sp    <= sp_next;
      rc    <= rc_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    eidx   <= eidx_next;
    cur    <= cur_next;
    top    <= top_next;
    och    <= och_next;
    olast  <= olast_next;
    ofault <= ofault_next;
  end

  always_ff @(posedge clk) begin
    if (push_en) stk[sp[AW-1:0]] <= push_data;
    stk_rd <= stk[sp_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (put_en) res[rc[AW-1:0]] <= put_data;
    res_rd <= res[eidx];
  end

endmodule

FILE: src/infix_to_prefix_converter.sv
// Infix to prefix converter.
// expr_in takes one word per character of an infix expression; expr_last marks
// the final character. prefix_out gives the prefix form one word per character,
// out_last on the final word, or a single word with fault set (out_char zero)
// on buffer overflow or unmatched parentheses, or a single zero word with
// out_last and no fault when the expression holds only parentheses.
// Loading takes one character per cycle while the loader is not waiting for
// the buffer. Once the last character is in, the back end scans the stored
// expression in reverse through operands, parentheses, operators and
// operator-stack pops, then emits the result words in reverse. Reads of the
// stack and result memories in the back-end sequencer are registered. The
// expression buffer is handed back to the loader as soon as the scan ends,
// so the next expression loads while words drain.
// A stalled receiver holds the output register and pauses emission; input
// keeps loading until the loader waits for the buffer.
// Reset (synchronous, active high) empties both ends and the job queue;
// buffer contents are left as they are.
module infix_to_prefix_converter (
  input  logic         clk,
  input  logic         rst,
  ipc_expr_if.sink     expr_in,
  ipc_prefix_if.source prefix_out
);

  // loader -> converter job handoff
  logic              job_push, job_full, job_pop, job_empty;
  ipc_pkg::job_t     job_in, job_out;
  // converter's read port and release on the expression buffer
  ipc_pkg::buf_ctl_t buf_ctl;
  logic [7:0]        buf_data;

  // Front end: store characters, count them, flag overflow.
  ipc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .expr_in  (expr_in),
    .job_push (job_push),
    .job_data (job_in),
    .job_full (job_full),
    .buf_ctl  (buf_ctl),
    .buf_data (buf_data)
  );

  // Short queue so each side stalls on its own.
  ipc_job_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  // Back end: reverse scan with operator stack, then drain results reversed.
  ipc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (job_out),
    .job_empty  (job_empty),
    .job_pop    (job_pop),
    .buf_ctl    (buf_ctl),
    .buf_data   (buf_data),
    .prefix_out (prefix_out)
  );

endmodule

FILE: src/ipc_checker.sv
`include "infix_to_prefix_converter_macros.svh"

module ipc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       out_fault
);

  `IPC_ASSERT(a_rst_no_out, clk, rst |=> !out_valid, "output valid after reset")
  `IPC_ASSERT_RST(a_fault_word, clk, rst, (out_valid && out_fault) |-> (out_char == 8'h00 && out_last), "fault word malformed")
  `IPC_ASSERT_RST(a_hold_after_last, clk, rst, (in_valid && in_ready && in_last) |=> !in_ready, "input taken while buffer busy")
  `IPC_ASSERT_RST(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last) && $stable(out_fault)), "stalled word changed")

endmodule

bind infix_to_prefix_converter ipc_checker u_ipc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (expr_in.valid),
  .in_ready  (expr_in.ready),
  .in_last   (expr_in.expr_last),
  .out_valid (prefix_out.valid),
  .out_ready (prefix_out.ready),
  .out_char  (prefix_out.out_char),
  .out_last  (prefix_out.out_last),
  .out_fault (prefix_out.fault)
);
